FILE: rtl/core/srfs_pkg.sv
package srfs_pkg;

    localparam int WORD_W          = 64;
    localparam int SHIFT_W         = 4;
    localparam int CFG_W           = 5;
    localparam int SEG_COUNT       = 4;
    localparam int MAX_SEGMENT_DEF = 16;

    // apb register map: 32-bit registers at word addresses; only register 0 (segment size) is mapped
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_SEG_SIZE   = '0;
    localparam logic [CFG_W-1:0]     SEG_SIZE_RESET = CFG_W'(16);

    typedef struct packed {
        logic               inverse;
        logic [WORD_W-1:0]  word;
        logic [SHIFT_W-1:0] shift;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              sign_negative;
        logic              shift_error;
    } t_res;

endpackage

FILE: rtl/core/segmented_rotate_fermion_sign.sv
// segmented rotation of a 64-bit occupation word with fermionic sign
//
// input channel: i_in_valid / o_in_ready with i_req_type, i_occupation_word and
// i_shift_amount. output channel: o_out_valid / i_out_ready with o_rotated_word,
// o_sign_negative and o_shift_error. one result per input transfer, in order.
// segment size is set through the apb port (register 0, reset 16, saturated to
// MAX_SEGMENT); write it only while no transfer is in flight.
//
// pipeline: a transfer goes into the input register, then its result into the
// result register that drives o_out_valid; two register stages in all (input
// register, result register). throughput: one item per cycle while i_out_ready
// stays high, set by the single-pass rotate and parity logic between them.
// when the receiver stalls the result register holds and the input register
// still takes one more item; o_in_ready falls only when both are full.
// reset (synchronous, active low) empties both stages and restores segment size 16.
module segmented_rotate_fermion_sign #(
    parameter int MAX_SEGMENT = srfs_pkg::MAX_SEGMENT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srfs_pkg::APB_AW-1:0]   paddr,
    input  logic [srfs_pkg::APB_DW-1:0]   pwdata,
    output logic [srfs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [srfs_pkg::WORD_W-1:0]   i_occupation_word,
    input  logic [srfs_pkg::SHIFT_W-1:0]  i_shift_amount,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [srfs_pkg::WORD_W-1:0]   o_rotated_word,
    output logic                          o_sign_negative,
    output logic                          o_shift_error
);
    import srfs_pkg::*;

    logic [CFG_W-1:0] seg_size;
    logic             r_s1_vld;
    t_req             r_s1;
    logic             r_out_vld;
    t_res             r_out;
    t_res             res;
    logic             adv;
    logic             in_xfer;

    srfs_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_seg_size (seg_size)
    );

    srfs_datapath #(
        .MAX_SEGMENT (MAX_SEGMENT)
    ) u_datapath (
        .i_req      (r_s1),
        .i_seg_size (seg_size),
        .o_res      (res)
    );

    assign adv        = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.inverse <= i_req_type;
            r_s1.word    <= i_occupation_word;
            r_s1.shift   <= i_shift_amount;
        end
        if (adv && r_s1_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_rotated_word  = r_out.word;
    assign o_sign_negative = r_out.sign_negative;
    assign o_shift_error   = r_out.shift_error;

    a_err_sign_plus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_shift_error |-> !o_sign_negative)
        else $error("error result with minus sign");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_vld && r_out_vld && !i_out_ready)
        else $error("input stalled while a stage is free");

endmodule

FILE: rtl/core/srfs_apb_regs.sv
module srfs_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srfs_pkg::APB_AW-1:0]  paddr,
    input  logic [srfs_pkg::APB_DW-1:0]  pwdata,
    output logic [srfs_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [srfs_pkg::CFG_W-1:0]   o_seg_size
);
    import srfs_pkg::*;

    logic [CFG_W-1:0]     r_seg_size;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_size <= SEG_SIZE_RESET;
        end else if (wr_en && (reg_idx == REG_SEG_SIZE)) begin
            r_seg_size <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_SEG_SIZE) begin
            prdata = APB_DW'(r_seg_size);
        end
    end

    assign o_seg_size = r_seg_size;

endmodule

FILE: rtl/core/srfs_lane.sv
module srfs_lane #(
    parameter int MAX_SEGMENT = srfs_pkg::MAX_SEGMENT_DEF
) (
    input  logic [MAX_SEGMENT-1:0]       i_seg,
    input  logic [srfs_pkg::CFG_W-1:0]   i_size,
    input  logic [srfs_pkg::SHIFT_W-1:0] i_shift,
    input  logic                         i_inverse,
    output logic [MAX_SEGMENT-1:0]       o_rot,
    output logic                         o_par
);
    import srfs_pkg::*;

    logic [MAX_SEGMENT-1:0] ones;
    logic [MAX_SEGMENT-1:0] seg_mask;
    logic [MAX_SEGMENT-1:0] low_mask;
    logic [MAX_SEGMENT-1:0] wrap_mask;
    logic [MAX_SEGMENT-1:0] seg_m;
    logic [MAX_SEGMENT-1:0] left;
    logic [MAX_SEGMENT-1:0] right;
    logic [CFG_W-1:0]       rest;

    assign ones      = '1;
    assign seg_mask  = ~(ones << i_size);
    assign low_mask  = ~(ones << i_shift);
    assign rest      = i_size - CFG_W'(i_shift);
    // wrapping bits: bottom ones going down, top ones going up
    assign wrap_mask = i_inverse ? low_mask : (low_mask << rest);
    assign seg_m     = i_seg & seg_mask;

    assign left  = i_inverse ? (seg_m >> i_shift) : (seg_m << i_shift);
    assign right = i_inverse ? (seg_m << rest)    : (seg_m >> rest);
    assign o_rot = (left | right) & seg_mask;

    // (p - k) * k is odd only when both the wrapped and the staying counts are odd
    assign o_par = (^(seg_m & wrap_mask)) & (^(seg_m & ~wrap_mask));

endmodule

FILE: rtl/core/srfs_datapath.sv
module srfs_datapath #(
    parameter int MAX_SEGMENT = srfs_pkg::MAX_SEGMENT_DEF
) (
    input  srfs_pkg::t_req             i_req,
    input  logic [srfs_pkg::CFG_W-1:0] i_seg_size,
    output srfs_pkg::t_res             o_res
);
    import srfs_pkg::*;

    localparam int OFS_W = $clog2(SEG_COUNT * MAX_SEGMENT);

    logic [CFG_W-1:0]       size_eff;
    logic [OFS_W-1:0]       ofs     [SEG_COUNT];
    logic [MAX_SEGMENT-1:0] seg     [SEG_COUNT];
    logic [MAX_SEGMENT-1:0] rot     [SEG_COUNT];
    logic [SEG_COUNT-1:0]   lane_par;
    logic [WORD_W-1:0]      rot_word;
    logic                   err;

    // sizes above the build limit saturate
    assign size_eff = (i_seg_size > CFG_W'(MAX_SEGMENT)) ? CFG_W'(MAX_SEGMENT) : i_seg_size;
    assign err      = (CFG_W'(i_req.shift) >= size_eff);

    for (genvar s = 0; s < SEG_COUNT; s++) begin : g_lane
        assign ofs[s] = OFS_W'(s * int'(size_eff));
        assign seg[s] = MAX_SEGMENT'(i_req.word >> ofs[s]);

        srfs_lane #(
            .MAX_SEGMENT (MAX_SEGMENT)
        ) u_lane (
            .i_seg     (seg[s]),
            .i_size    (size_eff),
            .i_shift   (i_req.shift),
            .i_inverse (i_req.inverse),
            .o_rot     (rot[s]),
            .o_par     (lane_par[s])
        );
    end

    always_comb begin
        rot_word = '0;
        for (int s = 0; s < SEG_COUNT; s++) begin
            rot_word = rot_word | (WORD_W'(rot[s]) << ofs[s]);
        end
    end

    always_comb begin
        if (err) begin
            o_res.word          = i_req.word;
            o_res.sign_negative = 1'b0;
            o_res.shift_error   = 1'b1;
        end else begin
            o_res.word          = rot_word;
            o_res.sign_negative = ^lane_par;
            o_res.shift_error   = 1'b0;
        end
    end

endmodule

FILE: dv/srfs_checker.sv
`timescale 1ns / 100ps

module srfs_checker
    import srfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic [APB_DW-1:0] prdata,
    input  logic              pready,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_req_type,
    input  logic [WORD_W-1:0] i_occupation_word,
    input  logic [SHIFT_W-1:0] i_shift_amount,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_rotated_word,
    input  logic              i_sign_negative,
    input  logic              i_shift_error,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int REPORT_CAP = 100;

    logic [CFG_W-1:0] seg_size_q = SEG_SIZE_RESET;
    t_res             rotations_due[$];
    int               mismatches = 0;

    function automatic t_res rotate_segments(logic [CFG_W-1:0] size_cfg, logic inverse,
                                             logic [WORD_W-1:0] word,
                                             logic [SHIFT_W-1:0] shift);
        t_res              res;
        int unsigned       size;
        int unsigned       wrapped;
        int unsigned       occupied;
        logic [WORD_W-1:0] seg_mask;
        logic [WORD_W-1:0] wrap_mask;
        logic [WORD_W-1:0] seg;
        logic [WORD_W-1:0] rot;
        logic              parity;
        size = (size_cfg > MAX_SEGMENT_DEF) ? MAX_SEGMENT_DEF : size_cfg;
        res  = '0;
        if (shift >= size) begin
            // out of range shift: word passes through untouched, upper bits kept
            res.word        = word;
            res.shift_error = 1'b1;
            return res;
        end
        seg_mask  = (64'd1 << size) - 64'd1;
        wrap_mask = (64'd1 << shift) - 64'd1;
        if (!inverse) begin
            wrap_mask = wrap_mask << (size - shift);
        end
        parity = 1'b0;
        for (int s = 0; s < SEG_COUNT; s++) begin
            seg      = (word >> (s * size)) & seg_mask;
            wrapped  = $countones(seg & wrap_mask);
            occupied = $countones(seg);
            parity   = parity ^ (((occupied - wrapped) * wrapped) % 2 == 1);
            if (inverse) begin
                rot = (seg >> shift) | (seg << (size - shift));
            end else begin
                rot = (seg << shift) | (seg >> (size - shift));
            end
            res.word = res.word | ((rot & seg_mask) << (s * size));
        end
        res.sign_negative = parity;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        // keep the log short when the design is badly broken
        if (mismatches < REPORT_CAP) begin
            $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            seg_size_q = SEG_SIZE_RESET;
            rotations_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rotations_due.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding",
                                    i_rotated_word, '0);
                end else begin
                    want = rotations_due.pop_front();
                    if (i_rotated_word !== want.word) begin
                        report_mismatch("rotated word", i_rotated_word, want.word);
                    end
                    if (i_sign_negative !== want.sign_negative) begin
                        report_mismatch("sign", WORD_W'(i_sign_negative),
                                        WORD_W'(want.sign_negative));
                    end
                    if (i_shift_error !== want.shift_error) begin
                        report_mismatch("shift error", WORD_W'(i_shift_error),
                                        WORD_W'(want.shift_error));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                rotations_due.insert(rotations_due.size(),
                                     rotate_segments(seg_size_q, i_req_type,
                                                     i_occupation_word, i_shift_amount));
            end
            if (psel && penable && pready) begin
                if (paddr[APB_AW-1:2] == REG_SEG_SIZE) begin
                    if (pwrite) begin
                        seg_size_q = pwdata[CFG_W-1:0];
                    end else if (prdata !== APB_DW'(seg_size_q)) begin
                        report_mismatch("segment size readback", WORD_W'(prdata),
                                        WORD_W'(seg_size_q));
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= rotations_due.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import srfs_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int TAIL_CYCLES  = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RAND_PER_SET = 94;

    localparam logic [APB_AW-1:0] SEG_SIZE_ADDR = APB_AW'({REG_SEG_SIZE, 2'b00});
    localparam logic [APB_AW-1:0] SPARE_ADDR    = APB_AW'({~REG_SEG_SIZE, 2'b00});

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                psel              = 1'b0;
    logic                penable           = 1'b0;
    logic                pwrite            = 1'b0;
    logic [APB_AW-1:0]   paddr             = '0;
    logic [APB_DW-1:0]   pwdata            = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid        = 1'b0;
    logic                o_in_ready;
    logic                i_req_type        = 1'b0;
    logic [WORD_W-1:0]   i_occupation_word = '0;
    logic [SHIFT_W-1:0]  i_shift_amount    = '0;
    logic                o_out_valid;
    logic                i_out_ready       = 1'b0;
    logic [WORD_W-1:0]   o_rotated_word;
    logic                o_sign_negative;
    logic                o_shift_error;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic        stall_en    = 1'b1;
    int unsigned stall_left  = 0;
    bit          gaps_en     = 1'b1;
    int unsigned seg_size    = SEG_SIZE_RESET;

    always #6 i_clk = ~i_clk;

    segmented_rotate_fermion_sign u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_occupation_word (i_occupation_word),
        .i_shift_amount    (i_shift_amount),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_rotated_word    (o_rotated_word),
        .o_sign_negative   (o_sign_negative),
        .o_shift_error     (o_shift_error)
    );

    srfs_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_occupation_word (i_occupation_word),
        .i_shift_amount    (i_shift_amount),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_rotated_word    (o_rotated_word),
        .i_sign_negative   (o_sign_negative),
        .i_shift_error     (o_shift_error),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // mostly back to back, some short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_en) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 2) != 0);
            stall_left  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(logic inverse, logic [WORD_W-1:0] word,
                                logic [SHIFT_W-1:0] shift);
        int unsigned gap;
        i_in_valid        <= 1'b1;
        i_req_type        <= inverse;
        i_occupation_word <= word;
        i_shift_amount    <= shift;
        do @(posedge i_clk); while (!o_in_ready);
        gap = gaps_en ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_access(logic write, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // waits for the pipe to empty first; upper data bits are junk the register must drop
    task automatic set_segment_size(logic [CFG_W-1:0] size);
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        apb_access(1'b1, SEG_SIZE_ADDR, ($urandom & ~APB_DW'(5'h1F)) | APB_DW'(size));
        apb_access(1'b0, SEG_SIZE_ADDR, '0);
        seg_size = 32'(size);
    endtask

    task automatic send_random_request();
        logic [WORD_W-1:0]  word;
        logic [SHIFT_W-1:0] shift;
        int unsigned        usable;
        int unsigned        r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            word = {$urandom, $urandom};
        end else if (r < 80) begin
            word = '0;
        end else if (r < 88) begin
            word = '1;
        end else begin
            word = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        end
        usable = (seg_size > MAX_SEGMENT_DEF) ? MAX_SEGMENT_DEF : seg_size;
        if (usable != 0 && $urandom_range(0, 99) < 85) begin
            shift = SHIFT_W'($urandom_range(0, usable - 1));
        end else begin
            shift = SHIFT_W'($urandom_range(0, 15));
        end
        send_request(1'($urandom_range(0, 1)), word, shift);
    endtask

    initial begin
        int unsigned size_table [12];
        size_table = '{16, 1, 2, 3, 5, 8, 11, 15, 0, 31, 17, 16};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-width segments straight out of reset
        send_request(1'b0, '1, 4'd0);
        send_request(1'b1, 64'h0123_4567_89AB_CDEF, 4'd0);
        send_request(1'b0, '1, 4'd15);
        send_request(1'b1, '0, 4'd15);
        send_request(1'b0, 64'h8000_8000_8000_8000, 4'd1);
        send_request(1'b1, 64'h0001_0001_0001_0001, 4'd1);
        send_request(1'b0, {4{16'hAAAA}}, 4'd4);
        send_request(1'b1, {4{16'h5555}}, 4'd7);
        send_request(1'b0, 64'hF00F_0FF0_1234_8001, 4'd8);
        send_request(1'b1, 64'hC003_8001_7FFE_0001, 4'd15);

        // narrow segments: upper bits dropped, unless the shift is out of range
        set_segment_size(5'd5);
        send_request(1'b0, '1, 4'd4);
        send_request(1'b1, '1, 4'd5);
        send_request(1'b0, 64'hFFFF_0000_000A_B3C5, 4'd3);
        send_request(1'b1, {$urandom, $urandom}, 4'd15);

        set_segment_size(5'd1);
        send_request(1'b0, '1, 4'd0);
        send_request(1'b1, '1, 4'd1);

        // zero size makes every shift an error
        set_segment_size(5'd0);
        send_request(1'b0, '1, 4'd0);
        send_request(1'b1, {$urandom, $urandom}, 4'd15);

        // sizes past the maximum saturate
        set_segment_size(5'd31);
        send_request(1'b0, '1, 4'd15);
        send_request(1'b1, 64'h8000_0000_0000_0001, 4'd15);
        set_segment_size(5'd17);
        send_request(1'b0, {$urandom, $urandom}, 4'd9);

        // a write to an unmapped register must leave segment size alone
        wait_all_results();
        apb_access(1'b1, SPARE_ADDR, APB_DW'(5'd2));
        send_request(1'b1, {$urandom, $urandom}, 4'd9);

        set_segment_size(5'd16);
        send_request(1'b0, {$urandom, $urandom}, 4'd0);
        send_request(1'b1, {$urandom, $urandom}, 4'd13);

        foreach (size_table[p]) begin
            set_segment_size(CFG_W'(size_table[p]));
            // every fourth set runs flat out on both sides
            gaps_en   = (p % 4 != 3);
            stall_en <= (p % 4 != 3);
            repeat (RAND_PER_SET) begin
                send_random_request();
                if ($urandom_range(0, 199) == 0) begin
                    wait_all_results();
                end
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
